// ===== design/hpc_pkg.sv =====
// Package for the heater PID controller: configuration, stage and mode types,
// register index codes. No dependencies.
`timescale 1ns / 1ps

package hpc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_RANGE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DRIVE   = 3'd6;

    localparam logic [14:0] FUNC_RANGE_RESET = 15'd160;
    localparam logic [7:0]  FULL_DRIVE_RESET = 8'd255;

    localparam int SUM_W   = 42;
    localparam int SHIFT_W = 12;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_FULL = 2'd1,
        MODE_OFF  = 2'd2,
        MODE_PID  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [15:0]        kp_gain;
        logic [15:0]        ki_gain_per_tick;
        logic [15:0]        kd_gain;
        logic signed [23:0] integral_min;
        logic signed [23:0] integral_max;
        logic [14:0]        functional_range;
        logic [7:0]         full_drive;
    } cfg_t;

    // error stage result
    typedef struct packed {
        logic signed [16:0] err;
        logic signed [23:0] acc;
        logic signed [16:0] diff;
        mode_t              mode;
        logic [7:0]         drive;
    } front_t;

    // product stage result
    typedef struct packed {
        logic signed [32:0] p_term;
        logic signed [39:0] i_term;
        logic signed [32:0] d_term;
        mode_t              mode;
        logic [7:0]         drive;
    } prod_t;

endpackage

// ===== design/hpc_in_if.sv =====
// Input channel of the heater PID controller: valid/ready plus one sample word.
// Depends on nothing.
`timescale 1ns / 1ps

interface hpc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measured_temp;
    logic signed [15:0] setpoint_temp;
    logic               heater_idle;

    modport source (output valid, output measured_temp, output setpoint_temp,
                    output heater_idle, input ready);
    modport sink   (input valid, input measured_temp, input setpoint_temp,
                    input heater_idle, output ready);
endinterface

// ===== design/hpc_out_if.sv =====
// Output channel of the heater PID controller: valid/ready plus drive word.
// Uses hpc_pkg for the mode type.
`timescale 1ns / 1ps

interface hpc_out_if;
    logic          valid;
    logic          ready;
    logic [7:0]    drive_level;
    hpc_pkg::mode_t control_mode;

    modport source (output valid, output drive_level, output control_mode,
                    input ready);
    modport sink   (input valid, input drive_level, input control_mode,
                    output ready);
endinterface

// ===== design/heater_pid_controller.sv =====
// Heater PID controller top level: config bank and three-stage pipeline.
// Uses hpc_pkg, hpc_in_if, hpc_out_if, hpc_cfg_regs, hpc_front, hpc_mult, hpc_sum.
//
//  channel   dir  handshake              word
//  in_ch     in   valid/ready            measured_temp, setpoint_temp, heater_idle
//  out_ch    out  valid/ready            drive_level, control_mode
//  cfg       in   cfg_wr_en, no wait     cfg_index, cfg_data
//
// One word accepted per cycle while out_ch is ready; a result passes the registers of
// the accept stage, multiply stage and sum/clamp stage in that order before it is
// offered on out_ch.
// Integral, D samples and tick counter update in the accept stage, so the next
// word may follow at once. Reset empties the pipe, zeroes state, loads register
// defaults. Each stage holds while the one behind it is full and not draining.
`timescale 1ns / 1ps

module heater_pid_controller
#(
    parameter int TICKS_PER_SAMPLE = 10,
    parameter int DRIVE_CLAMP      = 255
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    hpc_in_if.sink                          in_ch,
    hpc_out_if.source                       out_ch
);

    hpc_pkg::cfg_t    cfg;
    logic             front_valid, front_ready;
    hpc_pkg::front_t  front_data;
    logic             prod_valid, prod_ready;
    hpc_pkg::prod_t   prod_data;

    hpc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hpc_front #(.TICKS_PER_SAMPLE(TICKS_PER_SAMPLE)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_ch      (in_ch),
        .down_ready (front_ready),
        .down_valid (front_valid),
        .down_data  (front_data)
    );

    hpc_mult u_mult
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (front_valid),
        .up_ready   (front_ready),
        .up_data    (front_data),
        .down_ready (prod_ready),
        .down_valid (prod_valid),
        .down_data  (prod_data)
    );

    hpc_sum #(.DRIVE_CLAMP(DRIVE_CLAMP)) u_sum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .up_data  (prod_data),
        .out_ch   (out_ch)
    );

endmodule

// ===== design/hpc_cfg_regs.sv =====
// Configuration register bank for the heater PID controller.
// Uses hpc_pkg for index codes and the cfg_t struct.
`timescale 1ns / 1ps

module hpc_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output hpc_pkg::cfg_t                    cfg
);

    hpc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain          <= '0;
            cfg_reg.ki_gain_per_tick <= '0;
            cfg_reg.kd_gain          <= '0;
            cfg_reg.integral_min     <= '0;
            cfg_reg.integral_max     <= '0;
            cfg_reg.functional_range <= hpc_pkg::FUNC_RANGE_RESET;
            cfg_reg.full_drive       <= hpc_pkg::FULL_DRIVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hpc_pkg::CFG_KP_GAIN:      cfg_reg.kp_gain          <= cfg_data[15:0];
                hpc_pkg::CFG_KI_GAIN:      cfg_reg.ki_gain_per_tick <= cfg_data[15:0];
                hpc_pkg::CFG_KD_GAIN:      cfg_reg.kd_gain          <= cfg_data[15:0];
                hpc_pkg::CFG_INTEGRAL_MIN: cfg_reg.integral_min     <= $signed(cfg_data[23:0]);
                hpc_pkg::CFG_INTEGRAL_MAX: cfg_reg.integral_max     <= $signed(cfg_data[23:0]);
                hpc_pkg::CFG_FUNC_RANGE:   cfg_reg.functional_range <= cfg_data[14:0];
                hpc_pkg::CFG_FULL_DRIVE:   cfg_reg.full_drive       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/hpc_front.sv =====
// Accept stage: error, band decision, integral clamp, D samples, tick counter.
// Uses hpc_pkg types and the hpc_in_if channel.
`timescale 1ns / 1ps

module hpc_front
#(
    parameter int TICKS_PER_SAMPLE = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hpc_pkg::cfg_t     cfg,
    hpc_in_if.sink            in_ch,
    input  logic              down_ready,
    output logic              down_valid,
    output hpc_pkg::front_t   down_data
);

    localparam int TW = $clog2(TICKS_PER_SAMPLE + 1);
    localparam logic [TW-1:0] TICK_WRAP = TW'(TICKS_PER_SAMPLE);

    logic                 valid_reg;
    hpc_pkg::front_t      data_reg;
    hpc_pkg::front_t      data_next;

    logic signed [23:0]   integral_reg, integral_next;
    logic signed [15:0]   older_reg, older_next;
    logic signed [15:0]   newer_reg, newer_next;
    logic [TW-1:0]        tick_reg, tick_next, tick_inc;

    logic                 load;
    logic signed [16:0]   err;
    logic signed [16:0]   range_pos;
    logic signed [16:0]   range_neg;
    logic signed [24:0]   acc_sum;
    logic signed [23:0]   acc_clamped;

    assign in_ch.ready = !valid_reg || down_ready;
    assign load        = in_ch.valid && in_ch.ready;

    assign err       = {in_ch.setpoint_temp[15], in_ch.setpoint_temp}
                     - {in_ch.measured_temp[15], in_ch.measured_temp};
    assign range_pos = $signed({2'b00, cfg.functional_range});
    assign range_neg = -range_pos;
    assign acc_sum   = {integral_reg[23], integral_reg} + {{8{err[16]}}, err};
    assign tick_inc  = tick_reg + TW'(1);

    always_comb
    begin
        // min check wins, so crossed limits still land on one of them
        priority if (acc_sum < $signed({cfg.integral_min[23], cfg.integral_min}))
            acc_clamped = cfg.integral_min;
        else if (acc_sum > $signed({cfg.integral_max[23], cfg.integral_max}))
            acc_clamped = cfg.integral_max;
        else
            acc_clamped = acc_sum[23:0];
    end

    always_comb
    begin
        tick_next     = (tick_inc == TICK_WRAP) ? '0 : tick_inc;
        integral_next = integral_reg;
        older_next    = older_reg;
        newer_next    = newer_reg;

        data_next.err   = err;
        data_next.acc   = acc_clamped;
        data_next.diff  = {older_reg[15], older_reg} - {newer_reg[15], newer_reg};
        data_next.drive = '0;

        priority if (in_ch.heater_idle)
        begin
            data_next.mode = hpc_pkg::MODE_IDLE;
            integral_next  = '0;
        end
        else if (err > range_pos)
        begin
            data_next.mode  = hpc_pkg::MODE_FULL;
            data_next.drive = cfg.full_drive;
        end
        else if (err < range_neg || in_ch.setpoint_temp == 16'sd0)
        begin
            data_next.mode = hpc_pkg::MODE_OFF;
        end
        else
        begin
            data_next.mode = hpc_pkg::MODE_PID;
            integral_next  = acc_clamped;
            if (tick_next == '0)
            begin
                older_next = newer_reg;
                newer_next = in_ch.measured_temp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            integral_reg <= '0;
            older_reg    <= '0;
            newer_reg    <= '0;
            tick_reg     <= '0;
        end
        else
        begin
            if (in_ch.ready)
                valid_reg <= in_ch.valid;
            if (load)
            begin
                integral_reg <= integral_next;
                older_reg    <= older_next;
                newer_reg    <= newer_next;
                tick_reg     <= tick_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ===== design/hpc_mult.sv =====
// Product stage: the three gain multiplies, one register behind them.
// Uses hpc_pkg types.
`timescale 1ns / 1ps

module hpc_mult
(
    input  logic              clk,
    input  logic              rst_n,
    input  hpc_pkg::cfg_t     cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  hpc_pkg::front_t   up_data,
    input  logic              down_ready,
    output logic              down_valid,
    output hpc_pkg::prod_t    down_data
);

    logic             valid_reg;
    hpc_pkg::prod_t   data_reg;
    hpc_pkg::prod_t   data_next;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        data_next.p_term = $signed({1'b0, cfg.kp_gain}) * up_data.err;
        data_next.i_term = $signed({1'b0, cfg.ki_gain_per_tick}) * up_data.acc;
        data_next.d_term = $signed({1'b0, cfg.kd_gain}) * up_data.diff;
        data_next.mode   = up_data.mode;
        data_next.drive  = up_data.drive;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ===== design/hpc_sum.sv =====
// Output stage: term sum, scale by 2^-12, clamp, and the output register.
// Uses hpc_pkg types and the hpc_out_if channel.
`timescale 1ns / 1ps

module hpc_sum
#(
    parameter int DRIVE_CLAMP = 255
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  hpc_pkg::prod_t    up_data,
    hpc_out_if.source         out_ch
);

    localparam logic [7:0] CLAMP = 8'(DRIVE_CLAMP);
    localparam int QW = hpc_pkg::SUM_W - hpc_pkg::SHIFT_W;

    logic                              valid_reg;
    logic [7:0]                        drive_reg, drive_next;
    hpc_pkg::mode_t                    mode_reg;
    logic signed [hpc_pkg::SUM_W-1:0]  sum;
    logic [QW-1:0]                     quot;

    assign up_ready = !valid_reg || out_ch.ready;

    assign sum  = hpc_pkg::SUM_W'(up_data.p_term) + hpc_pkg::SUM_W'(up_data.i_term)
                + hpc_pkg::SUM_W'(up_data.d_term);
    assign quot = sum[hpc_pkg::SUM_W-1:hpc_pkg::SHIFT_W];

    always_comb
    begin
        drive_next = up_data.drive;
        if (up_data.mode == hpc_pkg::MODE_PID)
        begin
            // non-positive sum gives zero drive
            if (sum[hpc_pkg::SUM_W-1] || sum == '0)
                drive_next = '0;
            else if ((|quot[QW-1:8]) || quot[7:0] > CLAMP)
                drive_next = CLAMP;
            else
                drive_next = quot[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            drive_reg <= drive_next;
            mode_reg  <= up_data.mode;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.drive_level  = drive_reg;
    assign out_ch.control_mode = mode_reg;

endmodule
